// ===== src/max_pool_clamp_f32_defines.svh =====
// Assertion macros used by the max pooling top level.
`ifndef MAX_POOL_CLAMP_F32_DEFINES_SVH
`define MAX_POOL_CLAMP_F32_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define MPC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define MPC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define MPC_ASSERT_SAME(label, ante, cons)
`define MPC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== src/mpc_pkg.sv =====
// Package with constants, register codes and float helpers for the max pooling block.
`timescale 1ns / 1ps
package mpc_pkg;
  localparam int unsigned DEF_MAX_CHANNELS = 256;
  localparam int unsigned DEF_MAX_KERNEL = 256;
  localparam int unsigned DEF_LANES = 4;
  localparam int unsigned FW = 32;
  localparam int unsigned CFG_W = 9;
  localparam int unsigned IDX_W = 8;

  typedef enum logic [IDX_W-1:0] {
    REG_KERNEL_SIZE = 8'd0,
    REG_CHANNEL_COUNT = 8'd1,
    REG_CLAMP_MIN = 8'd2,
    REG_CLAMP_MAX = 8'd3
  } reg_idx_t;

  typedef logic [FW-1:0] fbits_t;

  // Maps a float onto an unsigned key whose order follows the numeric order.
  function automatic logic [FW-1:0] f_key(input fbits_t a);
    f_key = a[FW-1] ? ~a : (a | {1'b1, {(FW-1){1'b0}}});
  endfunction

  function automatic logic f_nan(input fbits_t a);
    f_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
  endfunction

  // Numeric a > b; false on any NaN and for two zeros.
  function automatic logic f_gt(input fbits_t a, input fbits_t b);
    f_gt = !f_nan(a) && !f_nan(b) && !((a[30:0] == 31'd0) && (b[30:0] == 31'd0))
           && (f_key(a) > f_key(b));
  endfunction
endpackage

// ===== src/mpc_ram.sv =====
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module mpc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             re,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ===== src/mpc_lane.sv =====
// One channel lane: running maximum update and output clamp.
`timescale 1ns / 1ps
module mpc_lane (
  input  logic                  first,
  input  mpc_pkg::fbits_t       x,
  input  mpc_pkg::fbits_t       held,
  input  mpc_pkg::fbits_t       cmin,
  input  mpc_pkg::fbits_t       cmax,
  output mpc_pkg::fbits_t       new_max,
  output mpc_pkg::fbits_t       clamped
);
  import mpc_pkg::*;
  fbits_t t;

  always_comb begin
    new_max = (first || f_gt(x, held)) ? x : held;
    t = f_gt(new_max, cmax) ? cmax : new_max;
    clamped = f_gt(cmin, t) ? cmin : t;
  end
endmodule

// ===== src/max_pool_clamp_f32.sv =====
// Top level of the streaming float32 max pooling block with output clamp.
//
//  channel | direction | handshake          | payload
//  s_*     | in        | s_tvalid/s_tready  | s_tdata: lanes of one channel group
//  m_*     | out       | m_tvalid/m_tready  | m_tdata, m_tuser, m_tlast
//  cfg_*   | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One beat is taken per cycle unless an output stall holds the input.
// The running maximum lives in a RAM with one row per channel group and a bypass
// for a row written by the previous beat. Reset clears the counters and sets the
// configuration to its defaults; the RAM holds nothing until written. A stall on the output holds
// the compare stage and, through it, the input.
`timescale 1ns / 1ps
`include "max_pool_clamp_f32_defines.svh"
module max_pool_clamp_f32 #(
  parameter int unsigned MAX_CHANNELS = mpc_pkg::DEF_MAX_CHANNELS,
  parameter int unsigned MAX_KERNEL = mpc_pkg::DEF_MAX_KERNEL,
  parameter int unsigned LANES = mpc_pkg::DEF_LANES
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [LANES*mpc_pkg::FW-1:0] s_tdata,  // lane0, lane1, ... from bit 0 up
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [LANES*mpc_pkg::FW-1:0] m_tdata,  // out_lane0, out_lane1, ... from bit 0 up
  output logic [$clog2(LANES+1)-1:0]  m_tuser,   // valid_lanes
  output logic                        m_tlast,   // last_of_pixel
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [mpc_pkg::IDX_W-1:0]   cfg_index,
  input  logic [mpc_pkg::FW-1:0]      cfg_data
);
  import mpc_pkg::*;

  localparam int unsigned ROWS = (MAX_CHANNELS + LANES - 1) / LANES;
  localparam int unsigned RW = $clog2(ROWS > 1 ? ROWS : 2);
  localparam int unsigned CW = $clog2(MAX_CHANNELS + LANES + 1);
  localparam int unsigned KW = $clog2(MAX_KERNEL + 1);
  localparam int unsigned VW = $clog2(LANES + 1);
  localparam int unsigned DW = LANES * FW;

  logic [CFG_W-1:0] kernel_size, channel_count;
  fbits_t clamp_min, clamp_max;

  logic [RW-1:0] row;
  logic [CW-1:0] base;
  logic [KW-1:0] kpos;

  logic [KW-1:0] kern, kpos_c;
  logic [CW-1:0] chans, base_c;
  logic [RW-1:0] row_c;
  logic lastgrp, last_k, accept;
  logic [VW-1:0] valid_c;

  logic s1_v, s1_first, s1_last_k, s1_lastgrp, s1_adv;
  logic [RW-1:0] s1_row;
  logic [VW-1:0] s1_valid;
  logic [DW-1:0] s1_x, fwd_data, rdata, held, new_max, clamped, wr_data;
  logic fwd_v;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_size <= CFG_W'(1);
      channel_count <= CFG_W'(4);
      clamp_min <= 32'hFF80_0000;
      clamp_max <= 32'h7F80_0000;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_KERNEL_SIZE: kernel_size <= cfg_data[CFG_W-1:0];
        REG_CHANNEL_COUNT: channel_count <= cfg_data[CFG_W-1:0];
        REG_CLAMP_MIN: clamp_min <= cfg_data;
        REG_CLAMP_MAX: clamp_max <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (kernel_size == '0) kern = KW'(1);
    else if (32'(kernel_size) > MAX_KERNEL) kern = KW'(MAX_KERNEL);
    else kern = KW'(kernel_size);
    if (channel_count == '0) chans = CW'(1);
    else if (32'(channel_count) > MAX_CHANNELS) chans = CW'(MAX_CHANNELS);
    else chans = CW'(channel_count);
    base_c = (base >= chans) ? '0 : base;
    row_c = (base >= chans) ? '0 : row;
    kpos_c = (kpos >= kern) ? '0 : kpos;
    lastgrp = (base_c + CW'(LANES)) >= chans;
    valid_c = lastgrp ? VW'(chans - base_c) : VW'(LANES);
    last_k = (kpos_c + KW'(1)) == kern;
  end

  assign s1_adv = !s1_v || !s1_last_k || !m_tvalid || m_tready;
  assign s_tready = !s1_v || s1_adv;
  assign accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
      base <= '0;
      kpos <= '0;
    end else if (accept) begin
      if (lastgrp) begin
        row <= '0;
        base <= '0;
        kpos <= last_k ? '0 : kpos_c + KW'(1);
      end else begin
        row <= row_c + RW'(1);
        base <= base_c + CW'(LANES);
        kpos <= kpos_c;
      end
    end
  end

  // Lanes beyond the channel count keep what the row already held.
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      wr_data[i*FW +: FW] = (32'(i) < 32'(s1_valid)) ? new_max[i*FW +: FW]
                                                     : held[i*FW +: FW];
    end
  end

  mpc_ram #(.WIDTH(DW), .DEPTH(ROWS)) u_ram (
    .clk(clk),
    .we(s1_v && s1_adv),
    .waddr(s1_row),
    .wdata(wr_data),
    .re(accept),
    .raddr(row_c),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (s_tready) begin
      s1_v <= s_tvalid;
    end
    if (accept) begin
      s1_row <= row_c;
      s1_first <= (kpos_c == '0);
      s1_last_k <= last_k;
      s1_lastgrp <= lastgrp;
      s1_valid <= valid_c;
      s1_x <= s_tdata;
      fwd_v <= s1_v && (s1_row == row_c);
      fwd_data <= wr_data;
    end
  end

  assign held = fwd_v ? fwd_data : rdata;

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    mpc_lane u_lane (
      .first(s1_first),
      .x(s1_x[i*FW +: FW]),
      .held(held[i*FW +: FW]),
      .cmin(clamp_min),
      .cmax(clamp_max),
      .new_max(new_max[i*FW +: FW]),
      .clamped(clamped[i*FW +: FW])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_v && s1_last_k && s1_adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (s1_v && s1_last_k && s1_adv) begin
      for (int i = 0; i < LANES; i++) begin
        m_tdata[i*FW +: FW] <= (32'(i) < 32'(s1_valid)) ? clamped[i*FW +: FW] : '0;
      end
      m_tuser <= s1_valid;
      m_tlast <= s1_lastgrp;
    end
  end

  `MPC_ASSERT_SAME(a_stall_source, !s_tready, s1_v && s1_last_k && m_tvalid)
  `MPC_ASSERT_SAME(a_lane_count, m_tvalid, m_tuser != '0)
  `MPC_ASSERT_NEXT(a_stage_hold, s1_v && !s1_adv, s1_v)
endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for the float32 max pooling block with output clamp.
`timescale 1ns / 1ps
module tb_top;
  import mpc_pkg::*;

  localparam int unsigned NL = DEF_LANES;
  localparam int unsigned MAXC = DEF_MAX_CHANNELS;
  localparam int unsigned MAXK = DEF_MAX_KERNEL;

  typedef struct {
    logic [31:0] lane [NL];
    logic [2:0]  count;
    logic        last;
  } pool_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [NL*32-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [NL*32-1:0] m_tdata;
  logic [$clog2(NL+1)-1:0] m_tuser;
  logic m_tlast;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  logic [NL*32-1:0] pending_groups [$];
  pool_result_t pooled_expected [$];

  logic [8:0] kern_reg = 9'd1;
  logic [8:0] chan_reg = 9'd4;
  logic [31:0] lo_reg = 32'hFF800000;
  logic [31:0] hi_reg = 32'h7F800000;
  logic [31:0] window_max [MAXC];
  int unsigned kern_pos = 0;
  int unsigned grp_pos = 0;

  int errors = 0;
  int beats_in = 0;
  int beats_out = 0;
  int phases = 0;
  bit taken = 1'b0;
  int src_gap = 0;
  int sink_stall = 0;
  bit no_gaps = 1'b0;
  int hold_req = 0;
  int hold_done = 0;

  max_pool_clamp_f32 i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic bit is_nan(logic [31:0] a);
    return (a[30:23] == 8'hFF) && (a[22:0] != 0);
  endfunction

  function automatic bit greater(logic [31:0] a, logic [31:0] b);
    if (is_nan(a) || is_nan(b)) return 1'b0;
    if (a[30:0] == 0 && b[30:0] == 0) return 1'b0;
    if (!a[31] && b[31]) return 1'b1;
    if (a[31] && !b[31]) return 1'b0;
    if (!a[31]) return a[30:0] > b[30:0];
    return a[30:0] < b[30:0];
  endfunction

  function automatic logic [31:0] clamped(logic [31:0] v);
    logic [31:0] t;
    t = v;
    if (greater(t, hi_reg)) t = hi_reg;
    if (greater(lo_reg, t)) t = lo_reg;
    return t;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] rand_float();
    case ($urandom_range(0, 9))
      0: return {$urandom_range(0, 1) == 1, 31'd0};
      1: return {$urandom_range(0, 1) == 1, 8'hFF, 23'd0};
      2: return {$urandom_range(0, 1) == 1, 8'hFF, 23'($urandom_range(1, 32'h7FFFFF))};
      3: return {$urandom_range(0, 1) == 1, 8'h00, 23'($urandom_range(1, 32'h7FFFFF))};
      4, 5: return {$urandom_range(0, 1) == 1, 8'($urandom_range(124, 130)), 23'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  task automatic pool_step(logic [NL*32-1:0] grp);
    int unsigned kern, chans, groups, base, valid;
    logic [31:0] x;
    pool_result_t res;
    kern = (kern_reg < 1) ? 1 : (kern_reg > MAXK) ? MAXK : kern_reg;
    chans = (chan_reg < 1) ? 1 : (chan_reg > MAXC) ? MAXC : chan_reg;
    groups = (chans + NL - 1) / NL;
    if (grp_pos >= groups) grp_pos = 0;
    if (kern_pos >= kern) kern_pos = 0;
    base = grp_pos * NL;
    valid = (chans - base > NL) ? NL : chans - base;
    for (int i = 0; i < NL; i++) begin
      x = grp[32*i +: 32];
      res.lane[i] = '0;
      if (i < valid) begin
        if (kern_pos == 0 || greater(x, window_max[base+i])) window_max[base+i] = x;
        res.lane[i] = clamped(window_max[base+i]);
      end
    end
    res.count = valid[2:0];
    res.last = (grp_pos + 1 == groups);
    if (kern_pos + 1 == kern) pooled_expected.push_back(res);
    grp_pos++;
    if (grp_pos >= groups) begin
      grp_pos = 0;
      kern_pos++;
      if (kern_pos >= kern) kern_pos = 0;
    end
  endtask

  always @(posedge clk) begin
    taken <= s_tvalid && s_tready && !rst;
    if (!rst && s_tvalid && s_tready) begin
      pool_step(s_tdata);
      beats_in++;
    end
    if (!rst && cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_KERNEL_SIZE: kern_reg = cfg_data[8:0];
        REG_CHANNEL_COUNT: chan_reg = cfg_data[8:0];
        REG_CLAMP_MIN: lo_reg = cfg_data;
        REG_CLAMP_MAX: hi_reg = cfg_data;
        default: ;
      endcase
    end
  end

  always @(posedge clk) begin
    pool_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      beats_out++;
      if (pooled_expected.size() == 0) begin
        $display("%0t: unexpected beat, actual data %h user %0d last %0b",
                 $time, m_tdata, m_tuser, m_tlast);
        errors++;
      end else begin
        want = pooled_expected.pop_front();
        for (int i = 0; i < NL; i++)
          if (m_tdata[32*i +: 32] !== want.lane[i]) begin
            $display("%0t: lane %0d expected %h actual %h", $time, i, want.lane[i],
                     m_tdata[32*i +: 32]);
            errors++;
          end
        if (m_tuser !== want.count) begin
          $display("%0t: valid lanes expected %0d actual %0d", $time, want.count, m_tuser);
          errors++;
        end
        if (m_tlast !== want.last) begin
          $display("%0t: last expected %0b actual %0b", $time, want.last, m_tlast);
          errors++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || taken) begin
      if (src_gap > 0) begin
        src_gap--;
        s_tvalid <= 1'b0;
      end else if (pending_groups.size() > 0) begin
        s_tdata <= pending_groups.pop_front();
        s_tvalid <= 1'b1;
        src_gap = gap_len();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    int g;
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_req != hold_done) begin
      hold_done++;
      sink_stall = 300;
      m_tready <= 1'b0;
    end else if (sink_stall > 0) begin
      sink_stall--;
      m_tready <= 1'b0;
    end else begin
      g = gap_len();
      if (g > 0) begin
        sink_stall = g - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    wait (pending_groups.size() == 0 && !s_tvalid && pooled_expected.size() == 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_window(int k, int c, logic [31:0] lo, logic [31:0] hi);
    write_reg(REG_KERNEL_SIZE, k);
    write_reg(REG_CHANNEL_COUNT, c);
    write_reg(REG_CLAMP_MIN, lo);
    write_reg(REG_CLAMP_MAX, hi);
    phases++;
  endtask

  task automatic push_group(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                            logic [31:0] d);
    pending_groups.push_back({d, c, b, a});
  endtask

  task automatic push_windows(int k, int c, int windows);
    int ke, ce;
    logic [NL*32-1:0] g;
    ke = (k < 1) ? 1 : (k > MAXK) ? MAXK : k;
    ce = (c < 1) ? 1 : (c > MAXC) ? MAXC : c;
    for (int n = 0; n < windows * ke * ((ce + NL - 1) / NL); n++) begin
      for (int i = 0; i < NL; i++) g[32*i +: 32] = rand_float();
      pending_groups.push_back(g);
    end
  endtask

  initial begin
    int k, c, n, total;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Defaults: one kernel element, four channels, open clamp.
    push_group(32'h0, 32'hFFFFFFFF, 32'h7F800000, 32'hFF800000);
    push_group(32'h80000000, 32'h7FC00000, 32'h00000001, 32'h7F7FFFFF);
    wait_drained();

    // Two kernel elements, six channels: NaN first and later, ties of zeros, tail group.
    set_window(2, 6, 32'hBF800000, 32'h40000000);
    push_group(32'h7FC00000, 32'h3F800000, 32'h80000000, 32'h40400000);
    push_group(32'hC0000000, 32'hBF000000, 32'hFFFFFFFF, 32'hFFFFFFFF);
    push_group(32'h3F800000, 32'h7FC00000, 32'h00000000, 32'hC0400000);
    push_group(32'h3F000000, 32'h7F800000, 32'h12345678, 32'h87654321);
    wait_drained();

    // Lower bound above the upper one, then NaN bounds.
    set_window(1, 6, 32'h40400000, 32'h40000000);
    push_group(32'h41000000, 32'hC1000000, 32'h7FC00000, 32'h0);
    push_group(32'h0, 32'h3F800000, 32'h0, 32'h0);
    wait_drained();
    set_window(1, 4, 32'h7FC00000, 32'hFFC00000);
    push_group(32'h7F800000, 32'hFF800000, 32'h3F800000, 32'h7FC00000);
    wait_drained();

    // Kernel shortened in the middle of a window.
    set_window(3, 4, 32'hFF800000, 32'h7F800000);
    push_group(32'h3F800000, 32'h40000000, 32'hBF800000, 32'h0);
    push_group(32'h40000000, 32'h3F800000, 32'hC0000000, 32'h80000000);
    wait_drained();
    write_reg(REG_KERNEL_SIZE, 1);
    push_group(32'h40800000, 32'h0, 32'h0, 32'h0);
    wait_drained();

    // Out-of-range register values and the largest sizes.
    set_window(0, 0, 32'hFF800000, 32'h7F800000);
    push_windows(0, 0, 6);
    wait_drained();
    set_window(511, 1, 32'hC2C80000, 32'h42C80000);
    push_windows(511, 1, 1);
    wait_drained();
    set_window(2, 300, 32'hFF800000, 32'h7F800000);
    push_windows(2, 300, 1);
    wait_drained();
    set_window(256, 2, 32'h00000000, 32'h7F800000);
    push_windows(256, 2, 1);
    wait_drained();

    // Long output stall while the input keeps offering beats.
    set_window(1, 8, 32'hFF800000, 32'h7F800000);
    hold_req++;
    push_windows(1, 8, 40);
    wait_drained();

    total = beats_in;
    while (total < 1400 + beats_in - total + total) begin
      if (beats_in >= 1400) break;
      k = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 4);
      c = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
      n = $urandom_range(1, 6);
      no_gaps = ($urandom_range(0, 4) == 0);
      set_window(k, c, ($urandom_range(0, 2) == 0) ? rand_float() : 32'hFF800000,
                 ($urandom_range(0, 2) == 0) ? rand_float() : 32'h7F800000);
      push_windows(k, c, n);
      wait_drained();
    end

    $display("Covered %0d input beats and %0d pooled results over %0d settings,",
             beats_in, beats_out, phases);
    $display("including float specials, tail groups, clamp corners and long stalls.");
    if (errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb_top failed");
    $finish;
  end
endmodule

// ===== max_pool_clamp_f32.f =====
+incdir+src
src/mpc_pkg.sv
src/mpc_ram.sv
src/mpc_lane.sv
src/max_pool_clamp_f32.sv
bench/tb_top.sv
